// ===== rtl/core/tasrl_pkg.sv =====
// shared types and constants of the two-axis slew-rate limiter
package tasrl_pkg;

	// field widths
	localparam int unsigned POS_W      = 19;
	localparam int unsigned VEL_W      = 21;
	localparam int unsigned MAXV_W     = 20;
	localparam int unsigned LIM_W      = 18;
	localparam int unsigned TIME_W     = 48;
	localparam int unsigned ERR_W      = POS_W + 1;
	localparam int unsigned MAG_W      = ERR_W;
	localparam int unsigned STEP_W     = MAXV_W + 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = MAXV_W;
	localparam int unsigned IN_DATA_W  = 88;
	localparam int unsigned OUT_DATA_W = 80;

	// fixed-point scaling
	localparam int unsigned ANGLE_FRAC_BITS = 16;
	localparam int unsigned TFB_DEFAULT     = 20;

	// below 0.001 rad the velocity estimate reads zero
	localparam logic [MAG_W-1:0] SMALL_ERR_LIMIT =
		MAG_W'((2 ** ANGLE_FRAC_BITS + 999) / 1000);

	// register reset values
	localparam logic [MAXV_W-1:0] MAX_VEL_RESET     = MAXV_W'(98304);
	localparam logic [LIM_W-1:0]  YAW_BOUND_RESET   = LIM_W'(205887);
	localparam logic [LIM_W-1:0]  PITCH_BOUND_RESET = LIM_W'(68616);

	// word kinds on the input stream
	localparam logic KIND_COMMAND = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPEED_CAP   = 2'd0,
		CFG_YAW_BOUND   = 2'd1,
		CFG_PITCH_BOUND = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_CALC,
		ST_MOVE
	} state_t;

	// divider control from the sequencer
	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

endpackage

// ===== rtl/core/tasrl_serial_div.sv =====
// bit-serial restoring divider: (mag << TIME_FRAC_BITS) / dt, one quotient bit per cycle
module tasrl_serial_div
	import tasrl_pkg::*;
#(
	parameter int unsigned TIME_FRAC_BITS = TFB_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  div_ctrl_t                 ctrl,
	input  logic [MAG_W-1:0]          mag,
	input  logic [TIME_FRAC_BITS:0]   dt,
	output logic [MAXV_W-1:0]         quot,
	output logic                      ovf
);

	localparam int unsigned DT_W = TIME_FRAC_BITS + 1;

	logic [MAG_W-1:0]  num_q;
	logic [DT_W-1:0]   rem_q;
	logic [MAXV_W-1:0] quot_q;
	logic              ovf_q;
	logic [DT_W:0]     trial;
	logic [DT_W:0]     trial_sub;
	logic              fits;

	// shift the next dividend bit into the partial remainder and try the subtract
	always_comb begin
		trial     = {rem_q, num_q[MAG_W-1]};
		trial_sub = trial - {1'b0, dt};
		fits      = (trial >= {1'b0, dt});
	end

	// one restoring step per cycle; quotient bits leaving the top mark overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (ctrl.load) begin
			ovf_q <= 1'b0;
		end else if (ctrl.step) begin
			ovf_q <= ovf_q | quot_q[MAXV_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			num_q  <= mag;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (ctrl.step) begin
			num_q  <= {num_q[MAG_W-2:0], 1'b0};
			rem_q  <= fits ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
			quot_q <= {quot_q[MAXV_W-2:0], fits};
		end
	end

	assign quot = quot_q;
	assign ovf  = ovf_q;

endmodule

// ===== rtl/core/two_axis_slew_rate_limiter.sv =====
// top level of the two-axis slew-rate limiter
//
// channel   dir  handshake             content
// s_axis    in   tvalid/tready         command (targets) or tick (time stamp)
// m_axis    out  tvalid/tready         positions and velocity estimates
// cfg       in   cfg_we, no wait       speed cap, yaw bound, pitch bound
//
// a command word and the first tick after reset are taken in idle, which the block stays in;
// every later tick runs through prep, a calc phase of serial steps and move, and the
// bit-serial divider, one quotient bit per cycle, sets the length of the calc phase.
// reset clears positions, goals, the time stamp and the registers to defaults.
// the result sits in an output register, so the next word is taken while it waits;
// a tick that finishes while that register is still full holds until it drains.
module two_axis_slew_rate_limiter
	import tasrl_pkg::*;
#(
	parameter int unsigned TIME_FRAC_BITS = TFB_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // yaw_target, pitch_target, tick_time, zero pad
	input  logic                   s_axis_tuser,  // kind
	// output stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,  // yaw_position, pitch_position,
	                                              // yaw_rate, pitch_rate
	// register writes
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned DT_W       = TIME_FRAC_BITS + 1;
	localparam int unsigned DIFF_W     = TIME_W + 1;
	localparam int unsigned CALC_STEPS = MAG_W + TIME_FRAC_BITS;
	localparam int unsigned CNT_W      = $clog2(CALC_STEPS);
	localparam logic [63:0] DT_DEF_WIDE = ((64'd1 << DT_W) + 64'd50) / 64'd100;
	localparam logic [DT_W-1:0]   DT_DEFAULT = DT_DEF_WIDE[DT_W-1:0];
	localparam logic [DIFF_W-1:0] TIME_ONE   = {{(DIFF_W-1){1'b0}}, 1'b1} << TIME_FRAC_BITS;
	localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(CALC_STEPS - 1);
	localparam logic [CNT_W-1:0]  CNT_MUL    = CNT_W'(DT_W);

	state_t state_q, state_d;

	logic [MAXV_W-1:0]       max_vel_q;
	logic [LIM_W-1:0]        yaw_lim_q, pitch_lim_q;
	logic signed [POS_W-1:0] yaw_now_q, pitch_now_q, yaw_goal_q, pitch_goal_q;
	logic [TIME_W-1:0]       prev_time_q;
	logic                    time_seen_q;
	logic [DIFF_W-1:0]       diff_q;
	logic [DT_W-1:0]         dt_q, dt_sel;
	logic                    dt_ok;
	logic signed [ERR_W-1:0] yaw_err_d, pitch_err_d, yaw_err_q, pitch_err_q;
	logic [MAG_W-1:0]        yaw_mag_d, pitch_mag_d, yaw_mag_q, pitch_mag_q;
	logic [MAXV_W-1:0]       mul_hi_q;
	logic [DT_W-1:0]         mul_lo_q;
	logic [MAXV_W:0]         mul_sum;
	logic [MAXV_W:0]         step_lim;
	logic [CNT_W-1:0]        cnt_q;
	div_ctrl_t               div_ctrl;
	logic [MAXV_W-1:0]       yaw_quot, pitch_quot;
	logic                    yaw_ovf, pitch_ovf;
	logic                    in_take, move_go;
	logic                    in_kind;
	logic signed [POS_W-1:0] in_yaw, in_pitch;
	logic [TIME_W-1:0]       in_time;
	logic signed [POS_W-1:0] yaw_next, pitch_next;
	logic signed [VEL_W-1:0] yaw_vel, pitch_vel;
	logic [OUT_DATA_W-1:0]   out_data_q;
	logic                    out_valid_q;

	// clamp a target to plus or minus its limit
	function automatic logic signed [POS_W-1:0] clamp_goal(
		input logic signed [POS_W-1:0] tgt,
		input logic [LIM_W-1:0]        lim
	);
		logic signed [POS_W-1:0] lim_s;
		begin
			lim_s = signed'({1'b0, lim});
			if (tgt > lim_s)
				return lim_s;
			else if (tgt < -lim_s)
				return -lim_s;
			else
				return tgt;
		end
	endfunction

	// step toward the goal by at most the step limit
	function automatic logic signed [POS_W-1:0] step_pos(
		input logic signed [POS_W-1:0] now,
		input logic signed [POS_W-1:0] goal,
		input logic signed [ERR_W-1:0] err,
		input logic [MAG_W-1:0]        mag,
		input logic [MAXV_W:0]         md
	);
		logic signed [STEP_W-1:0] now_w, md_w, sum_w;
		begin
			now_w = signed'({{(STEP_W-POS_W){now[POS_W-1]}}, now});
			md_w  = signed'({1'b0, md});
			sum_w = err[ERR_W-1] ? now_w - md_w : now_w + md_w;
			if ({1'b0, mag} > md)
				return signed'(sum_w[POS_W-1:0]);
			else
				return goal;
		end
	endfunction

	// capped, signed velocity estimate
	function automatic logic signed [VEL_W-1:0] est_vel(
		input logic signed [ERR_W-1:0] err,
		input logic [MAG_W-1:0]        mag,
		input logic [MAXV_W-1:0]       quot,
		input logic                    ovf,
		input logic [MAXV_W-1:0]       mv
	);
		logic [MAXV_W-1:0]       capped;
		logic signed [VEL_W-1:0] mag_v;
		begin
			capped = (ovf || quot > mv) ? mv : quot;
			mag_v  = signed'({1'b0, capped});
			if (mag < SMALL_ERR_LIMIT)
				return '0;
			else if (!err[ERR_W-1] && err != '0)
				return mag_v;
			else
				return -mag_v;
		end
	endfunction

	// input word fields
	assign in_kind  = s_axis_tuser;
	assign in_yaw   = signed'(s_axis_tdata[POS_W-1:0]);
	assign in_pitch = signed'(s_axis_tdata[2*POS_W-1:POS_W]);
	assign in_time  = s_axis_tdata[2*POS_W+TIME_W-1:2*POS_W];
	assign in_take  = s_axis_tvalid && s_axis_tready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and strobes
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		div_ctrl      = '0;
		move_go       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && in_kind == KIND_TICK && time_seen_q)
					state_d = ST_PREP;
			end
			ST_PREP: begin
				div_ctrl.load = 1'b1;
				state_d       = ST_CALC;
			end
			ST_CALC: begin
				div_ctrl.step = 1'b1;
				if (cnt_q == CNT_LAST)
					state_d = ST_MOVE;
			end
			ST_MOVE: begin
				if (!out_valid_q || m_axis_tready) begin
					move_go = 1'b1;
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// elapsed time, falling back to 0.02 s when out of range
	always_comb begin
		dt_ok  = !diff_q[DIFF_W-1] && (diff_q != '0) && (diff_q <= TIME_ONE);
		dt_sel = dt_ok ? diff_q[DT_W-1:0] : DT_DEFAULT;
	end

	// pre-move errors and their magnitudes
	always_comb begin
		yaw_err_d   = {yaw_goal_q[POS_W-1], yaw_goal_q} - {yaw_now_q[POS_W-1], yaw_now_q};
		pitch_err_d = {pitch_goal_q[POS_W-1], pitch_goal_q}
			- {pitch_now_q[POS_W-1], pitch_now_q};
		yaw_mag_d   = yaw_err_d[ERR_W-1] ? unsigned'(-yaw_err_d) : unsigned'(yaw_err_d);
		pitch_mag_d = pitch_err_d[ERR_W-1] ? unsigned'(-pitch_err_d) : unsigned'(pitch_err_d);
	end

	// shift-add multiplier step: speed cap times one bit of dt
	always_comb begin
		mul_sum  = {1'b0, mul_hi_q} + (mul_lo_q[0] ? {1'b0, max_vel_q} : '0);
		step_lim = {mul_hi_q, mul_lo_q[DT_W-1]};
	end

	// move and estimate, used in the final state
	always_comb begin
		yaw_next   = step_pos(yaw_now_q, yaw_goal_q, yaw_err_q, yaw_mag_q, step_lim);
		pitch_next = step_pos(pitch_now_q, pitch_goal_q, pitch_err_q, pitch_mag_q, step_lim);
		yaw_vel    = est_vel(yaw_err_q, yaw_mag_q, yaw_quot, yaw_ovf, max_vel_q);
		pitch_vel  = est_vel(pitch_err_q, pitch_mag_q, pitch_quot, pitch_ovf, max_vel_q);
	end

	// architectural state: registers, goals, positions, time stamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_vel_q    <= MAX_VEL_RESET;
			yaw_lim_q    <= YAW_BOUND_RESET;
			pitch_lim_q  <= PITCH_BOUND_RESET;
			yaw_goal_q   <= '0;
			pitch_goal_q <= '0;
			yaw_now_q    <= '0;
			pitch_now_q  <= '0;
			prev_time_q  <= '0;
			time_seen_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SPEED_CAP:   max_vel_q   <= cfg_data;
					CFG_YAW_BOUND:   yaw_lim_q   <= cfg_data[LIM_W-1:0];
					CFG_PITCH_BOUND: pitch_lim_q <= cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (in_take && in_kind == KIND_COMMAND) begin
				yaw_goal_q   <= clamp_goal(in_yaw, yaw_lim_q);
				pitch_goal_q <= clamp_goal(in_pitch, pitch_lim_q);
			end
			if (in_take && in_kind == KIND_TICK) begin
				prev_time_q <= in_time;
				time_seen_q <= 1'b1;
			end
			if (move_go) begin
				yaw_now_q   <= yaw_next;
				pitch_now_q <= pitch_next;
			end
		end
	end

	// per-tick working registers
	always_ff @(posedge clk) begin
		if (in_take && in_kind == KIND_TICK)
			diff_q <= {1'b0, in_time} - {1'b0, prev_time_q};
		if (state_q == ST_PREP) begin
			dt_q        <= dt_sel;
			yaw_err_q   <= yaw_err_d;
			pitch_err_q <= pitch_err_d;
			yaw_mag_q   <= yaw_mag_d;
			pitch_mag_q <= pitch_mag_d;
			mul_hi_q    <= '0;
			mul_lo_q    <= dt_sel;
		end else if (state_q == ST_CALC && cnt_q < CNT_MUL) begin
			mul_hi_q <= mul_sum[MAXV_W:1];
			mul_lo_q <= {mul_sum[0], mul_lo_q[DT_W-1:1]};
		end
	end

	// step counter for the serial units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_PREP) begin
			cnt_q <= '0;
		end else if (state_q == ST_CALC) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// one divider per axis, run side by side
	tasrl_serial_div #(
		.TIME_FRAC_BITS(TIME_FRAC_BITS)
	) u_yaw_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.mag    (yaw_mag_d),
		.dt     (dt_q),
		.quot   (yaw_quot),
		.ovf    (yaw_ovf)
	);

	tasrl_serial_div #(
		.TIME_FRAC_BITS(TIME_FRAC_BITS)
	) u_pitch_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.mag    (pitch_mag_d),
		.dt     (dt_q),
		.quot   (pitch_quot),
		.ovf    (pitch_ovf)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_go)
			out_data_q <= {pitch_vel, yaw_vel, pitch_next, yaw_next};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// the time stamp, once seen, stays seen
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(time_seen_q))
		else $error("time_seen cleared outside reset");

	// the final state is only reached from the serial phase
	a_move_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE && $past(state_q) != ST_MOVE) |-> $past(state_q) == ST_CALC)
		else $error("move state entered without a full serial phase");

	// a new result only comes out of the final state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_MOVE)
		else $error("result raised outside the final state");

	// the divisor is never zero and never above one second
	a_dt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC |-> (dt_q != '0 && DIFF_W'(dt_q) <= TIME_ONE))
		else $error("elapsed time out of range during division");

endmodule

// ===== sim/two_axis_slew_rate_limiter_tb.sv =====
// self-checking testbench of the two-axis slew-rate limiter
`timescale 1ns / 100ps

module two_axis_slew_rate_limiter_tb;
	import tasrl_pkg::*;

	localparam longint TIME_ONE    = longint'(1) << TFB_DEFAULT;
	localparam longint DT_FALLBACK = (TIME_ONE * 2 + 50) / 100;
	localparam longint STAMP_MASK  = (longint'(1) << TIME_W) - 1;
	localparam int     CYCLE_LIMIT = 400000;
	localparam int     SETTLE_CYCLES = 80;

	// one word on the input stream
	typedef struct {
		logic              kind;
		logic [POS_W-1:0]  yaw;
		logic [POS_W-1:0]  pitch;
		logic [TIME_W-1:0] stamp;
	} motion_word_t;

	// one word on the output stream
	typedef struct {
		logic signed [POS_W-1:0] yaw_pos;
		logic signed [POS_W-1:0] pitch_pos;
		logic signed [VEL_W-1:0] yaw_vel;
		logic signed [VEL_W-1:0] pitch_vel;
	} pose_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // yaw_target, pitch_target, tick_time, zero pad
	logic                  s_axis_tuser = 1'b0; // kind
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // yaw_position, pitch_position,
	                                            // yaw_rate, pitch_rate
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	two_axis_slew_rate_limiter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	motion_word_t pending_words[$];
	pose_t        pose_queue[$];
	int           words_queued = 0;
	int           words_taken = 0;
	int           mismatch_count = 0;
	int           cycle_count = 0;
	bit           in_taken = 1'b0;
	logic         idle_on = 1'b1;

	// shadow registers and state of the limiter
	longint max_vel_reg = longint'(MAX_VEL_RESET);
	longint yaw_lim_reg = longint'(YAW_BOUND_RESET);
	longint pitch_lim_reg = longint'(PITCH_BOUND_RESET);
	longint yaw_now = 0;
	longint pitch_now = 0;
	longint yaw_goal = 0;
	longint pitch_goal = 0;
	longint last_stamp = 0;
	bit     time_seen = 1'b0;

	// generator bookkeeping
	longint clock_stamp = 0;
	int     last_yaw_cmd = 0;
	int     last_pitch_cmd = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatch_count < 100)
			$display("mismatch %s: got %0d expected %0d at cycle %0d",
				what, got, want, cycle_count);
		mismatch_count++;
	endtask

	function automatic longint clamp_goal(input longint target, input longint bound);
		if (target > bound)
			return bound;
		if (target < -bound)
			return -bound;
		return target;
	endfunction

	// move one axis toward its goal and estimate its speed
	function automatic void slew_axis(inout longint pos, input longint goal,
		input longint max_step, input longint dt, output longint vel);
		longint err;
		longint mag;
		err = goal - pos;
		mag = (err < 0) ? -err : err;
		if (mag > max_step)
			pos = pos + ((err > 0) ? max_step : -max_step);
		else
			pos = goal;
		vel = (mag <<< TFB_DEFAULT) / dt;
		if (vel > max_vel_reg)
			vel = max_vel_reg;
		if (err <= 0)
			vel = -vel;
		if (mag * 1000 < (longint'(1) << ANGLE_FRAC_BITS))
			vel = 0;
	endfunction

	// update goals or advance both axes for one accepted word
	function automatic void advance_axes(input logic kind, input logic [IN_DATA_W-1:0] data);
		longint stamp;
		longint dt;
		longint max_step;
		longint yv;
		longint pv;
		pose_t  p;
		if (kind == KIND_COMMAND) begin
			yaw_goal = clamp_goal(longint'($signed(data[0 +: POS_W])), yaw_lim_reg);
			pitch_goal = clamp_goal(longint'($signed(data[POS_W +: POS_W])), pitch_lim_reg);
		end else if (!time_seen) begin
			last_stamp = longint'(data[2*POS_W +: TIME_W]);
			time_seen = 1'b1;
		end else begin
			stamp = longint'(data[2*POS_W +: TIME_W]);
			dt = stamp - last_stamp;
			last_stamp = stamp;
			if (dt <= 0 || dt > TIME_ONE)
				dt = DT_FALLBACK;
			max_step = (max_vel_reg * dt) >>> TFB_DEFAULT;
			slew_axis(yaw_now, yaw_goal, max_step, dt, yv);
			slew_axis(pitch_now, pitch_goal, max_step, dt, pv);
			p.yaw_pos = POS_W'(yaw_now);
			p.pitch_pos = POS_W'(pitch_now);
			p.yaw_vel = VEL_W'(yv);
			p.pitch_vel = VEL_W'(pv);
			pose_queue.push_back(p);
		end
	endfunction

	// compare one output word with the oldest expected pose
	task automatic check_pose(input logic [OUT_DATA_W-1:0] data);
		pose_t want;
		pose_t got;
		got.yaw_pos = data[0 +: POS_W];
		got.pitch_pos = data[POS_W +: POS_W];
		got.yaw_vel = data[2*POS_W +: VEL_W];
		got.pitch_vel = data[2*POS_W+VEL_W +: VEL_W];
		if (pose_queue.size() == 0) begin
			report_mismatch("unexpected word, yaw_position", got.yaw_pos, 0);
		end else begin
			want = pose_queue.pop_front();
			if (got.yaw_pos !== want.yaw_pos)
				report_mismatch("yaw_position", got.yaw_pos, want.yaw_pos);
			if (got.pitch_pos !== want.pitch_pos)
				report_mismatch("pitch_position", got.pitch_pos, want.pitch_pos);
			if (got.yaw_vel !== want.yaw_vel)
				report_mismatch("yaw_rate", got.yaw_vel, want.yaw_vel);
			if (got.pitch_vel !== want.pitch_vel)
				report_mismatch("pitch_rate", got.pitch_vel, want.pitch_vel);
		end
	endtask

	// monitor: handshakes sampled at the rising edge
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				in_taken = 1'b1;
				words_taken++;
				advance_axes(s_axis_tuser, s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready)
				check_pose(m_axis_tdata);
		end
	end

	// driver: next word presented at the falling edge
	always @(negedge clk) begin
		motion_word_t w;
		if (arst_n && (in_taken || !s_axis_tvalid)) begin
			if (pending_words.size() != 0 && !(idle_on && $urandom_range(99) < 28)) begin
				w = pending_words.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= w.kind;
				s_axis_tdata <= {2'b00, w.stamp, w.pitch, w.yaw};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		in_taken = 1'b0;
	end

	// receiver stalls
	always @(negedge clk) begin
		m_axis_tready <= !(idle_on && $urandom_range(99) < 28);
	end

	task automatic push_command(input int yaw, input int pitch);
		motion_word_t w;
		w.kind = KIND_COMMAND;
		w.yaw = POS_W'(yaw);
		w.pitch = POS_W'(pitch);
		w.stamp = TIME_W'({$urandom, $urandom});
		pending_words.push_back(w);
		words_queued++;
		last_yaw_cmd = yaw;
		last_pitch_cmd = pitch;
	endtask

	task automatic push_tick(input longint stamp);
		motion_word_t w;
		w.kind = KIND_TICK;
		w.yaw = POS_W'($urandom);
		w.pitch = POS_W'($urandom);
		w.stamp = TIME_W'(stamp);
		pending_words.push_back(w);
		words_queued++;
		clock_stamp = stamp & STAMP_MASK;
	endtask

	function automatic int near_target(input int base);
		int v;
		v = base + int'($urandom_range(200)) - 100;
		if (v > 262143)
			v = 262143;
		if (v < -262144)
			v = -262144;
		return v;
	endfunction

	// random mix: mostly ticks at control rates, some commands and odd time stamps
	task automatic queue_random(input int count);
		int unsigned pick;
		longint      step;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				push_command(int'($urandom_range(524287)) - 262144,
					int'($urandom_range(524287)) - 262144);
			end else if (pick < 30) begin
				push_command(near_target(last_yaw_cmd), near_target(last_pitch_cmd));
			end else begin
				pick = $urandom_range(99);
				if (pick < 45)
					step = $urandom_range(60000, 1000);
				else if (pick < 60)
					step = $urandom_range(1000, 1);
				else if (pick < 72)
					step = $urandom_range(TIME_ONE, 60000);
				else if (pick < 77)
					step = TIME_ONE;
				else if (pick < 82)
					step = 0;
				else if (pick < 87)
					step = -longint'($urandom_range(5000, 1));
				else if (pick < 92)
					step = TIME_ONE + 1 + $urandom_range(1 << 24);
				else
					step = longint'({$urandom, $urandom}) - clock_stamp;
				push_tick(clock_stamp + step);
			end
		end
	endtask

	// hold the sender until every word is taken and every pose has come back
	task automatic wait_quiet();
		while (words_taken != words_queued || pose_queue.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_settings(input logic [MAXV_W-1:0] max_vel,
		input logic [LIM_W-1:0] yaw_lim, input logic [LIM_W-1:0] pitch_lim);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SPEED_CAP;
		cfg_data <= max_vel;
		@(negedge clk);
		cfg_index <= CFG_YAW_BOUND;
		cfg_data <= CFG_DATA_W'(yaw_lim);
		@(negedge clk);
		cfg_index <= CFG_PITCH_BOUND;
		cfg_data <= CFG_DATA_W'(pitch_lim);
		@(negedge clk);
		cfg_we <= 1'b0;
		max_vel_reg = longint'(max_vel);
		yaw_lim_reg = longint'(yaw_lim);
		pitch_lim_reg = longint'(pitch_lim);
	endtask

	// stimulus phases
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: clamping, first tick, time stamp corner cases, small errors
		push_command(262143, -262144);
		push_tick(0);
		push_tick(0);
		push_tick(1);
		push_tick(1 + TIME_ONE);
		push_tick(clock_stamp + TIME_ONE + 1);
		push_tick(clock_stamp - 5);
		push_command(0, 0);
		push_tick(clock_stamp + TIME_ONE);
		push_tick(clock_stamp + TIME_ONE);
		push_command(65, -65);
		push_tick(clock_stamp + TIME_ONE);
		push_command(131, -131);
		push_tick(clock_stamp + TIME_ONE);
		push_tick(clock_stamp + TIME_ONE);
		push_tick(STAMP_MASK);
		push_tick(0);
		push_command(-262144, 262143);
		push_tick(100);
		push_tick(200);
		queue_random(100);
		wait_quiet();

		// widest settings, no idling on either side
		idle_on <= 1'b0;
		load_settings(20'hfffff, 18'h3ffff, 18'h3ffff);
		queue_random(120);
		wait_quiet();

		// everything zero: goals forced to zero, nothing moves
		idle_on <= 1'b1;
		load_settings('0, '0, '0);
		queue_random(60);
		wait_quiet();

		// random settings, sender paused halfway until all poses are back
		load_settings(MAXV_W'($urandom), LIM_W'($urandom), LIM_W'($urandom));
		queue_random(120);
		wait_quiet();
		queue_random(60);
		wait_quiet();

		// slowest nonzero speed
		load_settings(MAXV_W'(1), LIM_W'(1000), 18'h3ffff);
		queue_random(60);
		wait_quiet();

		// back to the reset values
		load_settings(MAX_VEL_RESET, YAW_BOUND_RESET, PITCH_BOUND_RESET);
		queue_random(80);
		wait_quiet();

		if (mismatch_count == 0 && pose_queue.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
